>>> hw/rtl/packet_buffer_drop_tail_scheduler_macros.svh
// ---------------------------------------------------------------------------
// packet buffer scheduler assertion macros
// clocked assertion wrappers, compiled out for synthesis
// ---------------------------------------------------------------------------
`ifndef PACKET_BUFFER_DROP_TAIL_SCHEDULER_MACROS_SVH
`define PACKET_BUFFER_DROP_TAIL_SCHEDULER_MACROS_SVH

`ifndef SYNTHESIS
// check held off while reset is high
`define PBDT_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("pbdt assertion failed");
// check also active during reset
`define PBDT_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("pbdt assertion failed");
`else
`define PBDT_ASSERT(label, prop)
`define PBDT_ASSERT_ALWAYS(label, prop)
`endif

`endif

>>> hw/rtl/pbdt_pkg.sv
// ---------------------------------------------------------------------------
// pbdt_pkg
// shared constants and types of the packet buffer scheduler
// ---------------------------------------------------------------------------
package pbdt_pkg;

   localparam int BUF_DEPTH_DEFAULT = 16;
   localparam int TIME_BITS_DEFAULT = 32;

   // configuration port
   localparam int CSR_ADDR_BITS     = 3;
   localparam int CSR_DATA_BITS     = 32;
   localparam int BUFFER_SIZE_BITS  = 5;
   localparam logic [BUFFER_SIZE_BITS-1:0] BUFFER_SIZE_RESET = 5'd1;
   localparam logic [CSR_ADDR_BITS-3:0]    REG_BUFFER_SIZE   = 1'b0;

   // stream payload widths
   localparam int REQ_DATA_BITS = 48;
   localparam int RSP_DATA_BITS = 64;
   localparam int FIELD_BITS    = 32;
   localparam int SERVICE_BITS  = 16;

   // control broadcast to every cell of the chain
   typedef struct packed {
      logic shift;
      logic load;
      logic clear;
   } cell_ctrl_type;

endpackage

>>> hw/rtl/pbdt_cell.sv
// ---------------------------------------------------------------------------
// pbdt_cell
// one slot of the finish time chain: holds, loads, clears or takes its neighbor
// ---------------------------------------------------------------------------
module pbdt_cell #(
   parameter int TIME_BITS = 32,
   parameter int OCC_BITS  = 5,
   parameter int INDEX     = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  pbdt_pkg::cell_ctrl_type ctrl,
   input  logic [OCC_BITS-1:0]    occupancy,
   input  logic [TIME_BITS-1:0]   load_value,
   input  logic [TIME_BITS-1:0]   next_value,
   input  logic                   next_valid,
   output logic [TIME_BITS-1:0]   value,
   output logic                   valid
);
   import pbdt_pkg::*;

   logic [TIME_BITS-1:0] value_ff, value_in;
   logic                 valid_ff, valid_in;
   logic                 selected;

   assign selected = (occupancy == OCC_BITS'(INDEX));

   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      if (ctrl.clear) begin
         valid_in = 1'b0;
      end else if (ctrl.shift) begin
         value_in = next_value;
         valid_in = next_valid;
      end else if (ctrl.load && selected) begin
         value_in = load_value;
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      value_ff <= value_in;
   end

   assign value = value_ff;
   assign valid = valid_ff;

endmodule

>>> hw/rtl/packet_buffer_drop_tail_scheduler.sv
// ---------------------------------------------------------------------------
// packet_buffer_drop_tail_scheduler
// drop-tail packet buffer timing: retire, admit or drop, schedule
// flow: capture request, retire expired entries one per cycle, decide, register response
// a new request is accepted only back in idle, after the previous response is registered;
//   the decide step waits while the output register still holds an untaken response
// reset: queue empty, buffer_size = 1, no response pending
// ---------------------------------------------------------------------------
`include "packet_buffer_drop_tail_scheduler_macros.svh"

module packet_buffer_drop_tail_scheduler #(
   parameter int BUF_DEPTH = pbdt_pkg::BUF_DEPTH_DEFAULT,
   parameter int TIME_BITS = pbdt_pkg::TIME_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // request stream
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [31:0] arrival_time, [47:32] service_time
   input  logic [pbdt_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   // last_packet
   input  logic                                req_tlast,
   // response stream
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [31:0] start_time, [63:32] finish_time
   output logic [pbdt_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   // [0] dropped
   output logic                                rsp_tuser,
   // configuration port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [pbdt_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [pbdt_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [pbdt_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                                csr_pready
);
   import pbdt_pkg::*;

   localparam int OCC_BITS = $clog2(BUF_DEPTH + 1);
   localparam int CAP_BITS = (OCC_BITS > BUFFER_SIZE_BITS) ? OCC_BITS : BUFFER_SIZE_BITS;
   localparam int SRV_MAX  = (TIME_BITS > SERVICE_BITS) ? TIME_BITS : SERVICE_BITS;
   localparam int SUM_BITS = SRV_MAX + 1;
   localparam int EXT_BITS = TIME_BITS + FIELD_BITS;

   // sequencer states
   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_RETIRE = 2'd1;
   localparam logic [1:0] S_DECIDE = 2'd2;

   // ------------------------------------------------------------------
   // configuration register
   // ------------------------------------------------------------------
   logic [BUFFER_SIZE_BITS-1:0] buffer_size_ff, buffer_size_in;
   logic                        csr_write;
   logic                        csr_hit;

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[CSR_ADDR_BITS-1:2] == REG_BUFFER_SIZE);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      buffer_size_in = buffer_size_ff;
      if (csr_write && csr_hit) begin
         buffer_size_in = csr_pwdata[BUFFER_SIZE_BITS-1:0];
      end
   end

   assign csr_prdata = csr_hit ? CSR_DATA_BITS'(buffer_size_ff) : '0;

   // ------------------------------------------------------------------
   // request capture
   // ------------------------------------------------------------------
   logic [1:0]              state_ff, state_in;
   logic [TIME_BITS-1:0]    arrival_ff, arrival_in;
   logic [SERVICE_BITS-1:0] service_ff, service_in;
   logic                    last_ff, last_in;
   logic [OCC_BITS-1:0]     occ_ff, occ_in;
   logic [TIME_BITS-1:0]    newest_ff, newest_in;
   logic                    req_take;
   logic [EXT_BITS-1:0]     arrival_ext;

   // arrival is masked to the time width (or zero-extended)
   assign arrival_ext = {TIME_BITS'(0), req_tdata[FIELD_BITS-1:0]};
   assign req_tready  = (state_ff == S_IDLE);
   assign req_take    = req_tvalid && req_tready;

   // ------------------------------------------------------------------
   // cell chain: cell 0 holds the oldest finish time
   // ------------------------------------------------------------------
   cell_ctrl_type        cell_ctrl;
   logic [TIME_BITS-1:0] value_vec [BUF_DEPTH];
   logic [BUF_DEPTH-1:0] valid_vec;
   logic [TIME_BITS-1:0] push_value;

   for (genvar i = 0; i < BUF_DEPTH; i++) begin : g_cell
      logic [TIME_BITS-1:0] nbr_value;
      logic                 nbr_valid;
      if (i == BUF_DEPTH - 1) begin : g_tail
         assign nbr_value = '0;
         assign nbr_valid = 1'b0;
      end else begin : g_body
         assign nbr_value = value_vec[i+1];
         assign nbr_valid = valid_vec[i+1];
      end
      pbdt_cell #(
         .TIME_BITS (TIME_BITS),
         .OCC_BITS  (OCC_BITS),
         .INDEX     (i)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (cell_ctrl),
         .occupancy  (occ_ff),
         .load_value (push_value),
         .next_value (nbr_value),
         .next_valid (nbr_valid),
         .value      (value_vec[i]),
         .valid      (valid_vec[i])
      );
   end

   // head entry finished at or before the arrival
   logic head_expired;
   assign head_expired = valid_vec[0] && (value_vec[0] <= arrival_ff);

   // ------------------------------------------------------------------
   // admission and scheduling
   // ------------------------------------------------------------------
   logic [CAP_BITS-1:0]  size_ext;
   logic [CAP_BITS-1:0]  capacity;
   logic                 drop;
   logic [TIME_BITS-1:0] start_calc;
   logic [SUM_BITS-1:0]  finish_sum;
   logic                 saturate;
   logic [TIME_BITS-1:0] finish_calc;
   logic                 decide_go;

   // out-of-range size: zero acts as one, above depth acts as depth
   assign size_ext = CAP_BITS'(buffer_size_ff);
   always_comb begin
      if (buffer_size_ff == '0) begin
         capacity = CAP_BITS'(1);
      end else if (size_ext > CAP_BITS'(BUF_DEPTH)) begin
         capacity = CAP_BITS'(BUF_DEPTH);
      end else begin
         capacity = size_ext;
      end
   end

   assign drop = (CAP_BITS'(occ_ff) >= capacity);

   // start after the newest held packet, if any
   assign start_calc = ((occ_ff != '0) && (newest_ff > arrival_ff)) ? newest_ff : arrival_ff;

   // saturating finish time
   assign finish_sum  = SUM_BITS'(start_calc) + SUM_BITS'(service_ff);
   assign saturate    = (finish_sum > SUM_BITS'({TIME_BITS{1'b1}}));
   assign finish_calc = saturate ? {TIME_BITS{1'b1}} : finish_sum[TIME_BITS-1:0];
   assign push_value  = finish_calc;

   // the output register must be free to hand over the response
   assign decide_go = (state_ff == S_DECIDE) && (!rsp_tvalid || rsp_tready);

   always_comb begin
      cell_ctrl.shift = (state_ff == S_RETIRE) && head_expired;
      cell_ctrl.load  = decide_go && !drop;
      cell_ctrl.clear = decide_go && last_ff;
   end

   // ------------------------------------------------------------------
   // sequencer
   // ------------------------------------------------------------------
   always_comb begin
      state_in   = state_ff;
      arrival_in = arrival_ff;
      service_in = service_ff;
      last_in    = last_ff;
      occ_in     = occ_ff;
      newest_in  = newest_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               arrival_in = arrival_ext[TIME_BITS-1:0];
               service_in = req_tdata[FIELD_BITS+SERVICE_BITS-1:FIELD_BITS];
               last_in    = req_tlast;
               state_in   = S_RETIRE;
            end
         end
         S_RETIRE: begin
            // one retirement per cycle, shifting the chain toward cell 0
            if (head_expired) begin
               occ_in = occ_ff - OCC_BITS'(1);
            end else begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (decide_go) begin
               if (last_ff) begin
                  occ_in = '0;
               end else if (!drop) begin
                  occ_in = occ_ff + OCC_BITS'(1);
               end
               if (!drop) begin
                  newest_in = finish_calc;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------------------
   // response register
   // ------------------------------------------------------------------
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_drop_ff, rsp_drop_in;
   logic [FIELD_BITS-1:0] rsp_start_ff, rsp_start_in;
   logic [FIELD_BITS-1:0] rsp_finish_ff, rsp_finish_in;
   logic [EXT_BITS-1:0]   start_ext;
   logic [EXT_BITS-1:0]   finish_ext;

   assign start_ext  = {FIELD_BITS'(0), start_calc};
   assign finish_ext = {FIELD_BITS'(0), finish_calc};

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_drop_in   = rsp_drop_ff;
      rsp_start_in  = rsp_start_ff;
      rsp_finish_in = rsp_finish_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (decide_go) begin
         rsp_valid_in  = 1'b1;
         rsp_drop_in   = drop;
         // dropped packets report zero times
         rsp_start_in  = drop ? '0 : start_ext[FIELD_BITS-1:0];
         rsp_finish_in = drop ? '0 : finish_ext[FIELD_BITS-1:0];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_drop_ff;
   assign rsp_tdata  = {rsp_finish_ff, rsp_start_ff};

   // ------------------------------------------------------------------
   // registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         occ_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
         buffer_size_ff <= BUFFER_SIZE_RESET;
      end else begin
         state_ff       <= state_in;
         occ_ff         <= occ_in;
         rsp_valid_ff   <= rsp_valid_in;
         buffer_size_ff <= buffer_size_in;
      end
      arrival_ff    <= arrival_in;
      service_ff    <= service_in;
      last_ff       <= last_in;
      newest_ff     <= newest_in;
      rsp_drop_ff   <= rsp_drop_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_finish_ff <= rsp_finish_in;
   end

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------
   // configuration port never waits
   `PBDT_ASSERT_ALWAYS(a_pready_high, csr_pready)
   // chain valid bits always agree with the occupancy count
   `PBDT_ASSERT(a_occ_matches_chain, ($countones(valid_vec) == int'(occ_ff)))
   // each retire cycle removes exactly one entry
   `PBDT_ASSERT(a_retire_one, (state_ff == S_RETIRE && head_expired) |=> (occ_ff == $past(occ_ff) - OCC_BITS'(1)))
   // a last packet leaves the queue empty
   `PBDT_ASSERT(a_last_clears, (decide_go && last_ff) |=> (occ_ff == '0))
   // a dropped packet carries zero times
   `PBDT_ASSERT(a_drop_zero, (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == '0))
   // admitted packets never overfill the chain
   `PBDT_ASSERT(a_no_overfill, (decide_go && !drop) |-> (occ_ff < OCC_BITS'(BUF_DEPTH)))

endmodule
